### sv/ostg_pkg.sv
package ostg_pkg;

   // Default sizing of the oscillator.
   localparam int unsigned PHASE_BITS_DEFAULT      = 32;
   localparam int unsigned TABLE_ADDR_BITS_DEFAULT = 10;
   localparam int unsigned SINE_FRAC_BITS_DEFAULT  = 15;

   // Depth of the queue between the phase front end and the scaling back end.
   localparam int unsigned QUEUE_DEPTH = 4;

   // Field widths fixed by the interface.
   localparam int unsigned STEP_W   = 32;
   localparam int unsigned AMP_W    = 11;
   localparam int unsigned OFFSET_W = 12;
   localparam int unsigned SAMPLE_W = 12;
   localparam int unsigned CSR_W    = 32;

   // Output range and the stereo bump.
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = 12'd4095;
   localparam logic [SAMPLE_W-1:0] STEREO_BUMP = 12'd1;

   // Register reset values.
   localparam logic [STEP_W-1:0]   PHASE_STEP_RESET = 32'd114085069;
   localparam logic [AMP_W-1:0]    AMPLITUDE_RESET  = 11'd1000;
   localparam logic [OFFSET_W-1:0] DC_OFFSET_RESET  = 12'd2000;

   // Fixed-point constants for building the sine table.
   localparam longint unsigned Q28_ONE     = 64'd1 << 28;
   localparam longint unsigned HALF_PI_Q28 = 64'd421657428;

   // Rounded-up reciprocals of the Taylor divisors (2n)(2n+1), n = 1..7.
   // Shifted right by 30 plus the divisor's bit count, the product with any
   // dividend below 2^30 equals the truncated quotient.
   localparam longint unsigned TAYLOR_RECIP_1 = ((64'd1 << 33) + 64'd5) / 64'd6;
   localparam longint unsigned TAYLOR_RECIP_2 = ((64'd1 << 35) + 64'd19) / 64'd20;
   localparam longint unsigned TAYLOR_RECIP_3 = ((64'd1 << 36) + 64'd41) / 64'd42;
   localparam longint unsigned TAYLOR_RECIP_4 = ((64'd1 << 37) + 64'd71) / 64'd72;
   localparam longint unsigned TAYLOR_RECIP_5 = ((64'd1 << 37) + 64'd109) / 64'd110;
   localparam longint unsigned TAYLOR_RECIP_6 = ((64'd1 << 38) + 64'd155) / 64'd156;
   localparam longint unsigned TAYLOR_RECIP_7 = ((64'd1 << 38) + 64'd209) / 64'd210;

   // Register indexes on the configuration port.
   typedef enum logic [1:0] {
      CSR_PHASE_STEP  = 2'd0,
      CSR_AMPLITUDE   = 2'd1,
      CSR_DC_OFFSET   = 2'd2,
      CSR_STEREO_MODE = 2'd3
   } csr_index_type;

   // Settings that the back end reads.
   typedef struct packed {
      logic [AMP_W-1:0]    amplitude;
      logic [OFFSET_W-1:0] dc_offset;
      logic                stereo_mode;
   } tone_cfg_type;

   // First-quadrant sine magnitude, sin(pi/2 * r / 2^qtr_bits), rounded to
   // frac_bits fraction bits. Taylor series in Horner form in Q28; this is
   // only evaluated at elaboration to fill the constant table.
   function automatic longint unsigned quarter_sine(input int unsigned r,
                                                    input int unsigned qtr_bits,
                                                    input int unsigned frac_bits);
      longint unsigned y;
      longint unsigned y2;
      longint unsigned p;
      longint unsigned t;
      longint unsigned s;
      longint unsigned recip;
      int unsigned     recip_shift;
      y  = (HALF_PI_Q28 * longint'(r)) >> qtr_bits;
      y2 = (y * y) >> 28;
      p  = Q28_ONE;
      for (int n = 7; n >= 1; n--) begin
         // Each Horner term stays below 2^30, so the reciprocal is exact.
         recip_shift = 30 + $clog2((2 * n) * (2 * n + 1));
         unique case (n)
            1:       recip = TAYLOR_RECIP_1;
            2:       recip = TAYLOR_RECIP_2;
            3:       recip = TAYLOR_RECIP_3;
            4:       recip = TAYLOR_RECIP_4;
            5:       recip = TAYLOR_RECIP_5;
            6:       recip = TAYLOR_RECIP_6;
            default: recip = TAYLOR_RECIP_7;
         endcase
         t = (((y2 * p) >> 28) * recip) >> recip_shift;
         p = (t > Q28_ONE) ? 64'd0 : (Q28_ONE - t);
      end
      s = (y * p) >> 28;
      s = (s + (64'd1 << (27 - frac_bits))) >> (28 - frac_bits);
      return s;
   endfunction

endpackage

### sv/ostg_front.sv
module ostg_front import ostg_pkg::*; #(
   parameter int unsigned PHASE_BITS      = PHASE_BITS_DEFAULT,
   parameter int unsigned TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEFAULT,
   parameter int unsigned SINE_FRAC_BITS  = SINE_FRAC_BITS_DEFAULT,
   localparam int unsigned ENTRY_W        = SINE_FRAC_BITS + 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [STEP_W-1:0]  phase_step,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_load_phase,
   input  logic [31:0]        req_start_phase,
   input  logic               req_end_of_block,
   input  logic               queue_full,
   output logic               push_valid,
   output logic [ENTRY_W-1:0] push_data
);

   localparam int unsigned QTR_BITS = TABLE_ADDR_BITS - 2;
   localparam int unsigned QTR_SIZE = 1 << QTR_BITS;
   localparam int unsigned MAG_W    = SINE_FRAC_BITS + 1;

   logic [PHASE_BITS-1:0]      phase_acc_ff;
   logic [PHASE_BITS-1:0]      phase_acc_in;
   logic [PHASE_BITS-1:0]      phase_now;
   logic [TABLE_ADDR_BITS-1:0] table_addr;
   logic [QTR_BITS-1:0]        quarter_pos;
   logic [QTR_BITS:0]          quarter_idx;
   logic                       negate;
   logic                       accept;
   logic [MAG_W-1:0]           sine_mag;
   logic [MAG_W-1:0]           qtab [QTR_SIZE+1];

   // Constant first-quadrant table, mirror point included.
   for (genvar k = 0; k <= QTR_SIZE; k++) begin : g_qtab
      assign qtab[k] = MAG_W'(quarter_sine(k, QTR_BITS, SINE_FRAC_BITS));
   end

   // A beat is taken whenever the queue has room for it.
   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   // The loaded phase takes effect for this very sample.
   assign phase_now = req_load_phase ? PHASE_BITS'(req_start_phase) : phase_acc_ff;

   always_comb begin
      phase_acc_in = phase_acc_ff;
      if (accept) begin
         phase_acc_in = phase_now + PHASE_BITS'(phase_step);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff <= '0;
      end else begin
         phase_acc_ff <= phase_acc_in;
      end
   end

   // Fold the full-turn address onto the quarter table.
   assign table_addr  = phase_now[PHASE_BITS-1 -: TABLE_ADDR_BITS];
   assign quarter_pos = table_addr[QTR_BITS-1:0];
   assign negate      = table_addr[TABLE_ADDR_BITS-1];
   assign quarter_idx = table_addr[QTR_BITS]
                        ? ((QTR_BITS+1)'(QTR_SIZE) - {1'b0, quarter_pos})
                        : {1'b0, quarter_pos};
   assign sine_mag    = qtab[quarter_idx];

   // Queue entry: end of block, sign, magnitude.
   assign push_valid = accept;
   assign push_data  = {req_end_of_block, negate, sine_mag};

endmodule

### sv/ostg_queue.sv
module ostg_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int unsigned PTR_W   = $clog2(DEPTH);
   localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]   entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               push_fire;
   logic               pop_fire;

   assign full      = (count_ff == COUNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign push_fire = push_valid && !full;
   assign pop_fire  = pop_ready && pop_valid;

   // Pointer and fill-count bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/ostg_back.sv
module ostg_back import ostg_pkg::*; #(
   parameter int unsigned SINE_FRAC_BITS = SINE_FRAC_BITS_DEFAULT,
   localparam int unsigned ENTRY_W       = SINE_FRAC_BITS + 3
) (
   input  logic                clock,
   input  logic                reset,
   input  tone_cfg_type        cfg,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  logic [ENTRY_W-1:0]  pop_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SAMPLE_W-1:0] rsp_sample_value,
   output logic                rsp_channel,
   output logic                rsp_frame_last,
   output logic                rsp_block_last
);

   localparam int unsigned MAG_W  = SINE_FRAC_BITS + 1;
   localparam int unsigned PROD_W = AMP_W + MAG_W;
   localparam int unsigned BASE_W = OFFSET_W + SINE_FRAC_BITS;
   localparam int unsigned SUM_W  = BASE_W + 1;

   // Product stage.
   logic                valid_a_ff;
   logic                valid_a_in;
   logic [PROD_W-1:0]   prod_a_ff;
   logic [PROD_W-1:0]   prod_a_in;
   logic                neg_a_ff;
   logic                neg_a_in;
   logic                eob_a_ff;
   logic                eob_a_in;

   // Output stage.
   logic                out_valid_ff;
   logic                out_valid_in;
   logic [SAMPLE_W-1:0] out_value_ff;
   logic [SAMPLE_W-1:0] out_value_in;
   logic                out_chan_ff;
   logic                out_chan_in;
   logic                out_last_ff;
   logic                out_last_in;
   logic                out_blast_ff;
   logic                out_blast_in;
   logic                eob_hold_ff;
   logic                eob_hold_in;

   logic                out_fire;
   logic                out_free;
   logic                take_b;
   logic                free_a;
   logic                pop_fire;
   logic [MAG_W-1:0]    pop_mag;
   logic [BASE_W-1:0]   base;
   logic [SUM_W-1:0]    sum_pos;
   logic [BASE_W-1:0]   diff_neg;
   logic [SAMPLE_W:0]   raw_pos;
   logic [SAMPLE_W-1:0] sample_mono;
   logic [SAMPLE_W-1:0] sample_final;

   // Stage handshakes: the output register frees up after its frame's last beat.
   assign out_fire  = out_valid_ff && !rsp_stall;
   assign out_free  = !out_valid_ff || (out_fire && out_last_ff);
   assign take_b    = valid_a_ff && out_free;
   assign free_a    = !valid_a_ff || take_b;
   assign pop_ready = free_a;
   assign pop_fire  = pop_valid && free_a;
   assign pop_mag   = pop_data[MAG_W-1:0];

   // Scale the table magnitude by the amplitude.
   always_comb begin
      valid_a_in = valid_a_ff;
      prod_a_in  = prod_a_ff;
      neg_a_in   = neg_a_ff;
      eob_a_in   = eob_a_ff;
      if (free_a) begin
         valid_a_in = pop_valid;
      end
      if (pop_fire) begin
         prod_a_in = PROD_W'(cfg.amplitude) * PROD_W'(pop_mag);
         neg_a_in  = pop_data[MAG_W];
         eob_a_in  = pop_data[MAG_W+1];
      end
   end

   // Add the offset, floor, clamp and apply the stereo bump.
   assign base     = {cfg.dc_offset, {SINE_FRAC_BITS{1'b0}}};
   assign sum_pos  = SUM_W'(base) + SUM_W'(prod_a_ff);
   assign diff_neg = base - BASE_W'(prod_a_ff);
   assign raw_pos  = sum_pos[SINE_FRAC_BITS +: SAMPLE_W+1];

   always_comb begin
      if (neg_a_ff) begin
         if (SUM_W'(prod_a_ff) > SUM_W'(base)) begin
            sample_mono = '0;
         end else begin
            sample_mono = diff_neg[SINE_FRAC_BITS +: SAMPLE_W];
         end
      end else if (raw_pos > (SAMPLE_W+1)'(SAMPLE_MAX)) begin
         sample_mono = SAMPLE_MAX;
      end else begin
         sample_mono = raw_pos[SAMPLE_W-1:0];
      end
      sample_final = sample_mono;
      if (cfg.stereo_mode && (sample_mono != SAMPLE_MAX)) begin
         sample_final = sample_mono + STEREO_BUMP;
      end
   end

   // Output register; a stereo frame stays for a left and a right beat.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_chan_in  = out_chan_ff;
      out_last_in  = out_last_ff;
      out_blast_in = out_blast_ff;
      eob_hold_in  = eob_hold_ff;
      if (take_b) begin
         out_valid_in = 1'b1;
         out_value_in = sample_final;
         out_chan_in  = 1'b0;
         out_last_in  = !cfg.stereo_mode;
         out_blast_in = !cfg.stereo_mode && eob_a_ff;
         eob_hold_in  = eob_a_ff;
      end else if (out_fire && !out_last_ff) begin
         out_chan_in  = 1'b1;
         out_last_in  = 1'b1;
         out_blast_in = eob_hold_ff;
      end else if (out_fire) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_a_ff   <= valid_a_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_a_ff    <= prod_a_in;
      neg_a_ff     <= neg_a_in;
      eob_a_ff     <= eob_a_in;
      out_value_ff <= out_value_in;
      out_chan_ff  <= out_chan_in;
      out_last_ff  <= out_last_in;
      out_blast_ff <= out_blast_in;
      eob_hold_ff  <= eob_hold_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_sample_value = out_value_ff;
   assign rsp_channel      = out_chan_ff;
   assign rsp_frame_last   = out_last_ff;
   assign rsp_block_last   = out_blast_ff;

endmodule

### sv/offset_sine_tone_generator_unit.sv
// Sine tone generator with a DC offset. Each accepted request beat is one
// sample tick: the phase accumulator (optionally loaded first from
// req_start_phase) addresses a constant quarter-wave sine table, the sine is
// scaled by the amplitude, added to the DC offset, floored and clamped to
// 0..4095, and the accumulator then advances by phase_step. Mono mode returns
// one response beat per tick; stereo mode returns the value plus one (4095
// stays 4095) twice, left then right. In mono the block sustains one tick
// per clock while rsp_stall is low; in stereo the rate is set by the response
// port carrying one sample per clock. A request beat passes the table lookup,
// the four-entry queue, the amplitude multiply and the output register; the
// queue keeps requests flowing while a response is stalled, until it fills.
// Configuration writes are meant to happen only while no tick is in flight.
module offset_sine_tone_generator_unit import ostg_pkg::*; #(
   parameter int unsigned PHASE_BITS      = PHASE_BITS_DEFAULT,
   parameter int unsigned TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEFAULT,
   parameter int unsigned SINE_FRAC_BITS  = SINE_FRAC_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_load_phase,
   input  logic [31:0]         req_start_phase,
   input  logic                req_end_of_block,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SAMPLE_W-1:0] rsp_sample_value,
   output logic                rsp_channel,
   output logic                rsp_frame_last,
   output logic                rsp_block_last,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [CSR_W-1:0]    csr_write_data
);

   localparam int unsigned ENTRY_W = SINE_FRAC_BITS + 3;

   logic [STEP_W-1:0]   phase_step_ff;
   logic [STEP_W-1:0]   phase_step_in;
   logic [AMP_W-1:0]    amplitude_ff;
   logic [AMP_W-1:0]    amplitude_in;
   logic [OFFSET_W-1:0] dc_offset_ff;
   logic [OFFSET_W-1:0] dc_offset_in;
   logic                stereo_mode_ff;
   logic                stereo_mode_in;
   tone_cfg_type        cfg;
   logic                queue_full;
   logic                push_valid;
   logic [ENTRY_W-1:0]  push_data;
   logic                pop_valid;
   logic                pop_ready;
   logic [ENTRY_W-1:0]  pop_data;

   // Configuration registers.
   always_comb begin
      phase_step_in  = phase_step_ff;
      amplitude_in   = amplitude_ff;
      dc_offset_in   = dc_offset_ff;
      stereo_mode_in = stereo_mode_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_PHASE_STEP:  phase_step_in  = csr_write_data[STEP_W-1:0];
            CSR_AMPLITUDE:   amplitude_in   = csr_write_data[AMP_W-1:0];
            CSR_DC_OFFSET:   dc_offset_in   = csr_write_data[OFFSET_W-1:0];
            CSR_STEREO_MODE: stereo_mode_in = csr_write_data[0];
            default:         stereo_mode_in = stereo_mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff  <= PHASE_STEP_RESET;
         amplitude_ff   <= AMPLITUDE_RESET;
         dc_offset_ff   <= DC_OFFSET_RESET;
         stereo_mode_ff <= 1'b0;
      end else begin
         phase_step_ff  <= phase_step_in;
         amplitude_ff   <= amplitude_in;
         dc_offset_ff   <= dc_offset_in;
         stereo_mode_ff <= stereo_mode_in;
      end
   end

   assign cfg.amplitude   = amplitude_ff;
   assign cfg.dc_offset   = dc_offset_ff;
   assign cfg.stereo_mode = stereo_mode_ff;

   // Phase accumulation and table lookup.
   ostg_front #(
      .PHASE_BITS      (PHASE_BITS),
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
      .SINE_FRAC_BITS  (SINE_FRAC_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .phase_step       (phase_step_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_load_phase   (req_load_phase),
      .req_start_phase  (req_start_phase),
      .req_end_of_block (req_end_of_block),
      .queue_full       (queue_full),
      .push_valid       (push_valid),
      .push_data        (push_data)
   );

   // Decoupling queue.
   ostg_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Scaling, clamping and beat generation.
   ostg_back #(
      .SINE_FRAC_BITS (SINE_FRAC_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_data         (pop_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_value (rsp_sample_value),
      .rsp_channel      (rsp_channel),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_block_last   (rsp_block_last)
   );

   // A right-channel beat only exists in stereo mode.
   a_right_only_stereo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_channel |-> stereo_mode_ff)
      else $error("right-channel beat outside stereo mode");

   // In mono mode every beat closes its frame on the left channel.
   a_mono_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !stereo_mode_ff |-> rsp_frame_last && !rsp_channel)
      else $error("mono beat not a single left frame");

   // The block marker only rides on the last beat of a frame.
   a_block_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_block_last |-> rsp_frame_last)
      else $error("block marker on a beat that is not frame last");

   // A delivered left beat of a stereo frame is followed by its right beat.
   a_left_then_right: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_frame_last |=>
         rsp_valid && rsp_channel && rsp_frame_last)
      else $error("left beat not followed by the right beat");

endmodule
